// ===== hw/rtl/nart_pkg.sv =====
`timescale 1ns / 1ps

package nart_pkg;

    localparam int TABLE_ENTRIES_DEF = 8;
    localparam int ADDR_BYTES_DEF    = 5;
    localparam int IN_ADDR_W         = 40;
    localparam int STATUS_W          = 3;
    localparam int INDEX_W           = 7;
    localparam logic [7:0] ASCII_ZERO = 8'd48;

    typedef enum logic [1:0] {
        OP_REGISTER = 2'd0,
        OP_SEARCH   = 2'd1,
        OP_VERIFY   = 2'd2,
        OP_SET      = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_FULL      = 3'd2,
        ST_MISMATCH  = 3'd3,
        ST_RANGE     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_VERIFY
    } t_state;

endpackage

// ===== hw/rtl/nart_ram.sv =====
`timescale 1ns / 1ps

module nart_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 9
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/node_address_registration_table.sv =====
`timescale 1ns / 1ps

// node address table with free entry allocation
// an item is taken when start is high and busy is low; its fields sit on the
// i_ ports in that cycle. busy stays high while the item is worked on.
// exactly one result per item appears on o_status, o_index and o_node_out
// for a single cycle with o_done high; the receiver cannot hold it off.
// register and search walk entries 1 to TABLE_ENTRIES-1 through one
// comparator, one entry per cycle off the registered table read port,
// and stop early on a match. verify reads the indexed entry in S_VERIFY;
// a registration request or a bad digit is answered at once, as is set.
// a new item may be given in the cycle o_done is high.
// reset (i_rst_n low at a clock edge) empties the controller and marks every
// entry as holding its reset contents ("0" bytes, node number 0) through
// per-entry valid flags, so no clearing pass is needed.
module node_address_registration_table #(
    parameter int TABLE_ENTRIES = nart_pkg::TABLE_ENTRIES_DEF,
    parameter int ADDR_BYTES    = nart_pkg::ADDR_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_op,
    input  logic [nart_pkg::IN_ADDR_W-1:0] i_address,
    input  logic [7:0]                     i_sender_char,
    input  logic [7:0]                     i_entry_index,
    input  logic [7:0]                     i_node_number,
    output logic                           o_done,
    output logic [nart_pkg::STATUS_W-1:0]  o_status,
    output logic [nart_pkg::INDEX_W-1:0]   o_index,
    output logic [7:0]                     o_node_out
);

    import nart_pkg::*;

    localparam int DEPTH = TABLE_ENTRIES + 1;
    localparam int IW    = $clog2(DEPTH);
    localparam int AW    = ADDR_BYTES * 8;
    localparam logic [AW-1:0] ADDR_RESET = {ADDR_BYTES{ASCII_ZERO}};
    localparam logic [IW-1:0] LAST_IDX   = IW'(TABLE_ENTRIES - 1);
    localparam logic [7:0]    MAX_IDX8   = 8'(TABLE_ENTRIES);
    localparam logic [INDEX_W-1:0] NONE_IDX = INDEX_W'(TABLE_ENTRIES);

    t_state              r_state, n_state;
    t_op                 r_op, n_op;
    logic [AW-1:0]       r_key, n_key;
    logic [IW-1:0]       r_idx, n_idx;
    logic [IW-1:0]       r_free, n_free;
    logic [DEPTH-1:0]    r_avalid, n_avalid;
    logic [DEPTH-1:0]    r_nvalid, n_nvalid;
    logic                r_done, n_done;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [INDEX_W-1:0]  r_index, n_index;
    logic [7:0]          r_node, n_node;

    logic [AW+IN_ADDR_W-1:0] in_ext;
    logic [AW-1:0]           in_key;
    logic [7:0]              digit;
    logic [IW-1:0]           rd_addr;
    logic                    a_we;
    logic [IW-1:0]           a_waddr;
    logic                    nd_we;
    logic [AW-1:0]           a_q;
    logic [7:0]              nd_q;
    logic [AW-1:0]           a_eff;
    logic [7:0]              nd_eff;
    logic                    hit;
    logic [IW-1:0]           free_cur;

    assign in_ext = {{AW{1'b0}}, i_address};
    assign in_key = in_ext[AW-1:0];
    assign digit  = i_sender_char - ASCII_ZERO;

    nart_ram #(
        .WIDTH (AW),
        .DEPTH (DEPTH)
    ) u_addr_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (r_key),
        .i_raddr (rd_addr),
        .o_rdata (a_q)
    );

    nart_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (nd_we),
        .i_waddr (i_entry_index[IW-1:0]),
        .i_wdata (i_node_number),
        .i_raddr (rd_addr),
        .o_rdata (nd_q)
    );

    // entries never written read as their reset contents
    assign a_eff    = r_avalid[r_idx] ? a_q : ADDR_RESET;
    assign nd_eff   = r_nvalid[r_idx] ? nd_q : 8'd0;
    assign hit      = (a_eff == r_key);
    assign free_cur = ((r_free == '0) && (a_eff[7:0] == ASCII_ZERO)) ? r_idx : r_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_done   <= 1'b0;
            r_avalid <= '0;
            r_nvalid <= '0;
        end else begin
            r_state  <= n_state;
            r_done   <= n_done;
            r_avalid <= n_avalid;
            r_nvalid <= n_nvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_idx    <= n_idx;
        r_free   <= n_free;
        r_status <= n_status;
        r_index  <= n_index;
        r_node   <= n_node;
    end

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_key    = r_key;
        n_idx    = r_idx;
        n_free   = r_free;
        n_avalid = r_avalid;
        n_nvalid = r_nvalid;
        n_done   = 1'b0;
        n_status = r_status;
        n_index  = r_index;
        n_node   = r_node;
        rd_addr  = r_idx + IW'(1);
        a_we     = 1'b0;
        a_waddr  = free_cur;
        nd_we    = 1'b0;

        case (r_state)
            S_IDLE: begin
                rd_addr = (t_op'(i_op) == OP_VERIFY) ? digit[IW-1:0] : IW'(1);
                if (start) begin
                    n_op   = t_op'(i_op);
                    n_key  = in_key;
                    n_node = 8'd0;
                    case (t_op'(i_op))
                        OP_REGISTER, OP_SEARCH: begin
                            n_idx   = IW'(1);
                            n_free  = '0;
                            n_state = S_SCAN;
                        end
                        OP_VERIFY: begin
                            if (i_sender_char == ASCII_ZERO) begin
                                // registration request
                                n_done   = 1'b1;
                                n_status = ST_OK;
                                n_index  = '0;
                            end else if ((i_sender_char < ASCII_ZERO) ||
                                         (digit > MAX_IDX8)) begin
                                n_done   = 1'b1;
                                n_status = ST_RANGE;
                                n_index  = NONE_IDX;
                            end else begin
                                n_idx   = digit[IW-1:0];
                                n_state = S_VERIFY;
                            end
                        end
                        OP_SET: begin
                            n_done = 1'b1;
                            if (i_entry_index > MAX_IDX8) begin
                                n_status = ST_RANGE;
                                n_index  = NONE_IDX;
                            end else begin
                                nd_we    = 1'b1;
                                n_nvalid[i_entry_index[IW-1:0]] = 1'b1;
                                n_status = ST_OK;
                                n_index  = INDEX_W'(i_entry_index[IW-1:0]);
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (hit) begin
                    n_done   = 1'b1;
                    n_status = ST_OK;
                    n_index  = INDEX_W'(r_idx);
                    n_node   = (r_op == OP_SEARCH) ? nd_eff : 8'd0;
                    n_state  = S_IDLE;
                end else if (r_idx == LAST_IDX) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                    if (r_op == OP_REGISTER) begin
                        if (free_cur != '0) begin
                            a_we     = 1'b1;
                            n_avalid[free_cur] = 1'b1;
                            n_status = ST_OK;
                            n_index  = INDEX_W'(free_cur);
                        end else begin
                            n_status = ST_FULL;
                            n_index  = NONE_IDX;
                        end
                    end else begin
                        n_status = ST_NOT_FOUND;
                        n_index  = NONE_IDX;
                    end
                end else begin
                    n_idx  = r_idx + IW'(1);
                    n_free = free_cur;
                end
            end

            S_VERIFY: begin
                n_done   = 1'b1;
                n_status = hit ? ST_OK : ST_MISMATCH;
                n_index  = INDEX_W'(r_idx);
                n_state  = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy       = (r_state != S_IDLE);
    assign o_done     = r_done;
    assign o_status   = r_status;
    assign o_index    = r_index;
    assign o_node_out = r_node;

endmodule
